FILE: rtl/tolerance_batch_inspector_top_assert.svh
// ---------------------------------------------------------------------------
// tolerance batch inspector assertion macros
// concurrent checks on clock, disabled while reset is high
// ---------------------------------------------------------------------------
`ifndef TOLERANCE_BATCH_INSPECTOR_TOP_ASSERT_SVH
`define TOLERANCE_BATCH_INSPECTOR_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// antecedent and consequent in the same cycle
`define TBI_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent in the cycle after the antecedent
`define TBI_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define TBI_ASSERT_SAME(lbl, ante, cons, msg)
`define TBI_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: rtl/tbi_pkg.sv
// ---------------------------------------------------------------------------
// tbi_pkg
// shared widths, codes and types of the tolerance batch inspector
// ---------------------------------------------------------------------------
package tbi_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int DEV_W       = SAMPLE_BITS + 1;
   localparam int BAND_W      = 23;
   localparam int CNT_W       = 16;
   localparam int TOTAL_W     = CNT_W + 1;
   localparam int SUM_W       = 40;
   localparam int MEAN_W      = 24;
   localparam int BATCH_W     = 24;
   localparam int MAX_BATCH   = 65535;
   localparam int DIV_STEPS   = SUM_W;
   localparam int STEP_W      = $clog2(DIV_STEPS + 1);
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 24;
   localparam int RSP_DATA_W  = 160;

   localparam logic [CSR_IDX_W-1:0] CSR_NOMINAL = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND    = 1'b1;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   typedef enum logic [1:0] {
      GRADE_ALL_PASS = 2'd0,
      GRADE_MOSTLY   = 2'd1,
      GRADE_FAILED   = 2'd2
   } grade_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV_LOAD,
      ST_DIV_RUN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic commit;
      logic clear;
   } stats_ctrl_type;

   typedef struct packed {
      logic signed [DEV_W-1:0] dev;
      logic                    ok;
      logic                    close;
   } item_eval_type;

   typedef struct packed {
      logic        [CNT_W-1:0]       passed;
      logic        [CNT_W-1:0]       failed;
      logic signed [SAMPLE_BITS-1:0] run_min;
      logic signed [SAMPLE_BITS-1:0] run_max;
      logic        [SAMPLE_BITS-1:0] worst;
      logic        [SUM_W-1:0]       sum;
   } stats_type;

   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic                     busy;
      logic signed [MEAN_W-1:0] mean;
   } div_status_type;

   typedef struct packed {
      logic        [3:0]             pad;
      logic        [1:0]             batch_grade;
      logic signed [MEAN_W-1:0]      mean_value;
      logic        [SAMPLE_BITS-1:0] worst_deviation;
      logic signed [SAMPLE_BITS-1:0] largest;
      logic signed [SAMPLE_BITS-1:0] smallest;
      logic        [CNT_W-1:0]       fail_count;
      logic        [CNT_W-1:0]       pass_count;
      logic                          in_tolerance;
      logic signed [DEV_W-1:0]       deviation;
   } rsp_data_type;

endpackage

FILE: rtl/tolerance_batch_inspector_top.sv
// ---------------------------------------------------------------------------
// tolerance_batch_inspector_top
// checks measurements against nominal and band, keeps batch statistics
// ---------------------------------------------------------------------------
// usage:
//   req channel carries one measurement per item in req_tdata, with req_tlast
//   marking the last item of a batch. every item yields exactly one rsp item
//   with deviation, pass flag and running batch figures; rsp_tlast is high on
//   the item that closes a batch, which also carries mean and grade.
//   a batch also closes by itself when it reaches 65535 items. the user must
//   write nominal and band over csr only while no item is open; not enforced by the block.
// timing:
//   an ordinary item passes evaluate and output load before it reaches
//   rsp_tvalid, and the block takes no new item until it is back in idle.
//   a batch-closing item also passes divider load and divider run before its
//   output load, and the next item is taken only after it: the mean comes
//   from one shared restoring divider that retires one quotient bit per cycle
//   over the 40-bit running sum.
//   req_tready is high only while the sequencer is idle; the output register
//   holds a finished item until rsp_tready, and a new item may be accepted
//   meanwhile, but it stalls before its own output load.
// reset:
//   synchronous reset clears state, config, batch statistics, divider count and rsp_tvalid.
// ---------------------------------------------------------------------------
`include "tolerance_batch_inspector_top_assert.svh"

module tolerance_batch_inspector_top (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata: [23:0] measurement
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [tbi_pkg::SAMPLE_BITS-1:0]       req_tdata,
   input  logic                                 req_tlast,
   // rsp_tdata: [24:0] deviation, [25] in_tolerance, [41:26] pass_count,
   //   [57:42] fail_count, [81:58] smallest, [105:82] largest,
   //   [129:106] worst_deviation, [153:130] mean_value, [155:154] batch_grade,
   //   [159:156] zero
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [tbi_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic                                 rsp_tlast,
   input  logic                                 csr_we,
   input  logic [tbi_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [tbi_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   tbi_pkg::state_type state_ff, state_in;

   logic signed [tbi_pkg::SAMPLE_BITS-1:0] nominal_ff;
   logic        [tbi_pkg::BAND_W-1:0]      band_ff;

   logic signed [tbi_pkg::SAMPLE_BITS-1:0] meas_ff, meas_in;
   logic                                   last_ff, last_in;
   logic signed [tbi_pkg::DEV_W-1:0]       dev_ff, dev_in;
   logic                                   ok_ff, ok_in;
   logic                                   close_ff, close_in;

   logic                                   rsp_valid_ff, rsp_valid_in;
   tbi_pkg::rsp_data_type                  rsp_data_ff, rsp_data_in;
   logic                                   rsp_last_ff, rsp_last_in;

   tbi_pkg::stats_ctrl_type                stats_ctrl;
   tbi_pkg::item_eval_type                 eval;
   tbi_pkg::stats_type                     stats;
   tbi_pkg::div_ctrl_type                  div_ctrl;
   tbi_pkg::div_status_type                div_status;

   logic [tbi_pkg::TOTAL_W-1:0]            total;
   logic [tbi_pkg::TOTAL_W+2:0]            pass_x5;
   logic [tbi_pkg::TOTAL_W+2:0]            total_x4;
   logic                                   out_free;
   logic                                   out_load;
   tbi_pkg::grade_type                     grade;

   tbi_stats u_stats (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (stats_ctrl),
      .measurement    (meas_ff),
      .last_item      (last_ff),
      .nominal_value  (nominal_ff),
      .tolerance_band (band_ff),
      .eval           (eval),
      .stats          (stats)
   );

   tbi_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (stats.sum),
      .divisor  (total),
      .status   (div_status)
   );

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         nominal_ff <= '0;
         band_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            tbi_pkg::CSR_NOMINAL: nominal_ff <= csr_wdata[tbi_pkg::SAMPLE_BITS-1:0];
            tbi_pkg::CSR_BAND:    band_ff    <= csr_wdata[tbi_pkg::BAND_W-1:0];
            default:              ;
         endcase
      end
   end

   // batch grade from the committed counts
   always_comb begin
      total    = tbi_pkg::TOTAL_W'(stats.passed) + tbi_pkg::TOTAL_W'(stats.failed);
      pass_x5  = (tbi_pkg::TOTAL_W+3)'({stats.passed, 2'b00}) +
                 (tbi_pkg::TOTAL_W+3)'(stats.passed);
      total_x4 = (tbi_pkg::TOTAL_W+3)'({total, 2'b00});
      if (stats.failed == '0) begin
         grade = tbi_pkg::GRADE_ALL_PASS;
      end else if (pass_x5 >= total_x4) begin
         grade = tbi_pkg::GRADE_MOSTLY;
      end else begin
         grade = tbi_pkg::GRADE_FAILED;
      end
   end

   always_comb begin
      state_in          = state_ff;
      meas_in           = meas_ff;
      last_in           = last_ff;
      dev_in            = dev_ff;
      ok_in             = ok_ff;
      close_in          = close_ff;
      stats_ctrl.commit = 1'b0;
      stats_ctrl.clear  = 1'b0;
      div_ctrl.start    = 1'b0;
      req_tready        = 1'b0;
      out_free          = !rsp_valid_ff || rsp_tready;
      out_load          = 1'b0;
      rsp_valid_in      = rsp_valid_ff && !rsp_tready;
      rsp_data_in       = rsp_data_ff;
      rsp_last_in       = rsp_last_ff;

      unique case (state_ff)
         tbi_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               meas_in  = req_tdata;
               last_in  = req_tlast;
               state_in = tbi_pkg::ST_EVAL;
            end
         end
         tbi_pkg::ST_EVAL: begin
            stats_ctrl.commit = 1'b1;
            dev_in            = eval.dev;
            ok_in             = eval.ok;
            close_in          = eval.close;
            state_in          = eval.close ? tbi_pkg::ST_DIV_LOAD : tbi_pkg::ST_EMIT;
         end
         tbi_pkg::ST_DIV_LOAD: begin
            div_ctrl.start = 1'b1;
            state_in       = tbi_pkg::ST_DIV_RUN;
         end
         tbi_pkg::ST_DIV_RUN: begin
            if (!div_status.busy) begin
               state_in = tbi_pkg::ST_EMIT;
            end
         end
         tbi_pkg::ST_EMIT: begin
            if (out_free) begin
               out_load                    = 1'b1;
               rsp_valid_in                = 1'b1;
               rsp_last_in                 = close_ff;
               rsp_data_in.pad             = '0;
               rsp_data_in.deviation       = dev_ff;
               rsp_data_in.in_tolerance    = ok_ff;
               rsp_data_in.pass_count      = stats.passed;
               rsp_data_in.fail_count      = stats.failed;
               rsp_data_in.smallest        = stats.run_min;
               rsp_data_in.largest         = stats.run_max;
               rsp_data_in.worst_deviation = stats.worst;
               rsp_data_in.mean_value      = close_ff ? div_status.mean : '0;
               rsp_data_in.batch_grade     = close_ff ? grade : tbi_pkg::GRADE_ALL_PASS;
               stats_ctrl.clear            = close_ff;
               state_in                    = tbi_pkg::ST_IDLE;
            end
         end
         default: state_in = tbi_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tbi_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      meas_ff     <= meas_in;
      last_ff     <= last_in;
      dev_ff      <= dev_in;
      ok_ff       <= ok_in;
      close_ff    <= close_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   `TBI_ASSERT_NEXT(a_clear_after_close, out_load && close_ff,
      stats.passed == '0 && stats.failed == '0, "batch not cleared after closing item")
   `TBI_ASSERT_SAME(a_div_only_in_run, div_status.busy,
      state_ff == tbi_pkg::ST_DIV_RUN, "divider busy outside the divide step")
   `TBI_ASSERT_SAME(a_emit_counts_nonzero, out_load,
      total != '0, "item emitted with empty batch counts")
   `TBI_ASSERT_SAME(a_grade_matches_fails, out_load && close_ff,
      (stats.failed == '0) == (grade == tbi_pkg::GRADE_ALL_PASS),
      "grade disagrees with fail count")

endmodule

FILE: rtl/tbi_stats.sv
// ---------------------------------------------------------------------------
// tbi_stats
// per-item tolerance check and running batch statistics
// ---------------------------------------------------------------------------
module tbi_stats (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tbi_pkg::stats_ctrl_type               ctrl,
   input  logic signed [tbi_pkg::SAMPLE_BITS-1:0] measurement,
   input  logic                                  last_item,
   input  logic signed [tbi_pkg::SAMPLE_BITS-1:0] nominal_value,
   input  logic        [tbi_pkg::BAND_W-1:0]      tolerance_band,
   output tbi_pkg::item_eval_type                eval,
   output tbi_pkg::stats_type                    stats
);

   tbi_pkg::stats_type stats_ff, stats_in;
   logic open_ff, open_in;

   logic signed [tbi_pkg::DEV_W-1:0]   dev;
   logic        [tbi_pkg::DEV_W-1:0]   adev;
   logic                               ok;
   logic        [tbi_pkg::TOTAL_W-1:0] total;
   logic        [tbi_pkg::SUM_W-1:0]   meas_ext;

   always_comb begin
      dev      = tbi_pkg::DEV_W'(measurement) - tbi_pkg::DEV_W'(nominal_value);
      adev     = dev[tbi_pkg::DEV_W-1] ? tbi_pkg::DEV_W'(-dev) : tbi_pkg::DEV_W'(dev);
      ok       = adev <= tbi_pkg::DEV_W'(tolerance_band);
      meas_ext = tbi_pkg::SUM_W'(measurement);

      stats_in = stats_ff;
      open_in  = 1'b1;
      // first item of a batch loads min and max
      if (!open_ff || measurement < stats_ff.run_min) begin
         stats_in.run_min = measurement;
      end
      if (!open_ff || measurement > stats_ff.run_max) begin
         stats_in.run_max = measurement;
      end
      if (adev[tbi_pkg::SAMPLE_BITS-1:0] > stats_ff.worst) begin
         stats_in.worst = adev[tbi_pkg::SAMPLE_BITS-1:0];
      end
      stats_in.sum = stats_ff.sum + meas_ext;
      if (ok) begin
         if (stats_ff.passed != tbi_pkg::CNT_MAX) begin
            stats_in.passed = stats_ff.passed + 1'b1;
         end
      end else begin
         if (stats_ff.failed != tbi_pkg::CNT_MAX) begin
            stats_in.failed = stats_ff.failed + 1'b1;
         end
      end
      total = tbi_pkg::TOTAL_W'(stats_in.passed) + tbi_pkg::TOTAL_W'(stats_in.failed);

      eval.dev   = dev;
      eval.ok    = ok;
      eval.close = last_item ||
                   (tbi_pkg::BATCH_W'(total) >= tbi_pkg::BATCH_W'(tbi_pkg::MAX_BATCH));
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         stats_ff <= '0;
         open_ff  <= 1'b0;
      end else if (ctrl.commit) begin
         stats_ff <= stats_in;
         open_ff  <= open_in;
      end
   end

   assign stats = stats_ff;

endmodule

FILE: rtl/tbi_divider.sv
// ---------------------------------------------------------------------------
// tbi_divider
// restoring divider, one quotient bit per cycle, for the batch mean
// ---------------------------------------------------------------------------
module tbi_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  tbi_pkg::div_ctrl_type             ctrl,
   input  logic [tbi_pkg::SUM_W-1:0]          dividend,
   input  logic [tbi_pkg::TOTAL_W-1:0]        divisor,
   output tbi_pkg::div_status_type           status
);

   logic [tbi_pkg::STEP_W-1:0]  cnt_ff, cnt_in;
   logic [tbi_pkg::SUM_W-1:0]   dvd_ff, dvd_in;
   logic [tbi_pkg::TOTAL_W-1:0] rem_ff, rem_in;
   logic [tbi_pkg::TOTAL_W-1:0] dsr_ff, dsr_in;
   logic                        neg_ff, neg_in;

   logic [tbi_pkg::TOTAL_W:0]   shifted;
   logic                        fits;
   logic [tbi_pkg::TOTAL_W:0]   diff;
   logic [tbi_pkg::SUM_W-1:0]   quot;
   logic                        over_pos;
   logic                        over_neg;

   always_comb begin
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      neg_in  = neg_ff;
      shifted = {rem_ff, dvd_ff[tbi_pkg::SUM_W-1]};
      fits    = shifted >= {1'b0, dsr_ff};
      diff    = shifted - {1'b0, dsr_ff};
      if (ctrl.start) begin
         neg_in = dividend[tbi_pkg::SUM_W-1];
         dvd_in = neg_in ? (~dividend + 1'b1) : dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = tbi_pkg::STEP_W'(tbi_pkg::DIV_STEPS);
      end else if (cnt_ff != '0) begin
         rem_in = fits ? diff[tbi_pkg::TOTAL_W-1:0] : shifted[tbi_pkg::TOTAL_W-1:0];
         dvd_in = {dvd_ff[tbi_pkg::SUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      neg_ff <= neg_in;
   end

   // saturate the signed quotient to the mean range
   always_comb begin
      quot     = dvd_ff;
      over_pos = quot > tbi_pkg::SUM_W'({1'b0, {(tbi_pkg::MEAN_W-1){1'b1}}});
      over_neg = quot > tbi_pkg::SUM_W'({1'b1, {(tbi_pkg::MEAN_W-1){1'b0}}});
      status.busy = cnt_ff != '0;
      if (neg_ff) begin
         status.mean = over_neg ? {1'b1, {(tbi_pkg::MEAN_W-1){1'b0}}}
                                : tbi_pkg::MEAN_W'(~quot + 1'b1);
      end else begin
         status.mean = over_pos ? {1'b0, {(tbi_pkg::MEAN_W-1){1'b1}}}
                                : quot[tbi_pkg::MEAN_W-1:0];
      end
   end

endmodule

FILE: tb/inspection_checker.sv
// ---------------------------------------------------------------------------
// inspection_checker
// watches the csr port and both item channels of the tolerance batch
// inspector, works out the expected report for every accepted measurement
// and compares each delivered report with the oldest one still waiting
// ---------------------------------------------------------------------------
module inspection_checker
   import tbi_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [SAMPLE_BITS-1:0] req_tdata,
   input  logic                   req_tlast,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   rsp_tlast,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     mismatches,
   output int                     pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      rsp_data_type fields;
      logic         closes;
   } report_type;

   report_type expected_reports[$];
   int         reports_seen;

   // limits as last written
   logic signed [SAMPLE_BITS-1:0] nominal;
   logic        [BAND_W-1:0]      band;

   // running figures of the open batch
   logic        [CNT_W-1:0]       passed;
   logic        [CNT_W-1:0]       failed;
   logic signed [SAMPLE_BITS-1:0] run_min;
   logic signed [SAMPLE_BITS-1:0] run_max;
   logic        [SAMPLE_BITS-1:0] run_worst;
   logic        [SUM_W-1:0]       run_sum;
   logic                          batch_started;

   task automatic clear_batch();
      passed        = '0;
      failed        = '0;
      run_min       = '0;
      run_max       = '0;
      run_worst     = '0;
      run_sum       = '0;
      batch_started = 1'b0;
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatches++;
      $display("%0t: report %0d, %s: got %h, expected %h",
               $realtime, reports_seen, what, got, want);
   endtask

   task automatic compare_field(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      if (got !== want)
         report_mismatch(what, got, want);
   endtask

   task automatic inspect_measurement(input logic [SAMPLE_BITS-1:0] raw, input logic last);
      longint     m;
      longint     dev;
      longint     adev;
      longint     total;
      longint     mean;
      logic       ok;
      logic       closes;
      report_type r;

      m    = longint'($signed(raw));
      dev  = m - longint'(nominal);
      adev = (dev < 0) ? -dev : dev;
      ok   = adev <= longint'(band);

      // first item of a batch seeds min and max
      if (!batch_started) begin
         run_min       = raw;
         run_max       = raw;
         batch_started = 1'b1;
      end
      if (m < longint'(run_min))
         run_min = raw;
      if (m > longint'(run_max))
         run_max = raw;
      if (adev > longint'(run_worst))
         run_worst = adev[SAMPLE_BITS-1:0];
      run_sum = run_sum + m[SUM_W-1:0];

      if (ok) begin
         if (passed != CNT_MAX)
            passed++;
      end else begin
         if (failed != CNT_MAX)
            failed++;
      end
      total  = longint'(passed) + longint'(failed);
      closes = last || (total >= MAX_BATCH);

      r.fields                 = '0;
      r.fields.deviation       = dev[DEV_W-1:0];
      r.fields.in_tolerance    = ok;
      r.fields.pass_count      = passed;
      r.fields.fail_count      = failed;
      r.fields.smallest        = run_min;
      r.fields.largest         = run_max;
      r.fields.worst_deviation = run_worst;
      r.closes                 = closes;

      if (closes && total != 0) begin
         mean = longint'($signed(run_sum)) / total;
         if (mean > 8388607)
            mean = 8388607;
         if (mean < -8388608)
            mean = -8388608;
         r.fields.mean_value = mean[MEAN_W-1:0];
         if (longint'(passed) == total)
            r.fields.batch_grade = GRADE_ALL_PASS;
         else if (longint'(passed) * 5 >= total * 4)
            r.fields.batch_grade = GRADE_MOSTLY;
         else
            r.fields.batch_grade = GRADE_FAILED;
      end

      expected_reports.push_back(r);
      if (closes)
         clear_batch();
   endtask

   task automatic check_report();
      rsp_data_type got;
      report_type   want;

      got = rsp_data_type'(rsp_tdata);
      reports_seen++;
      if (expected_reports.size() == 0) begin
         report_mismatch("report with nothing expected", rsp_tdata[63:0], '0);
         return;
      end
      want = expected_reports.pop_front();
      compare_field("deviation",       got.deviation,       want.fields.deviation);
      compare_field("in_tolerance",    got.in_tolerance,    want.fields.in_tolerance);
      compare_field("pass_count",      got.pass_count,      want.fields.pass_count);
      compare_field("fail_count",      got.fail_count,      want.fields.fail_count);
      compare_field("smallest",        got.smallest,        want.fields.smallest);
      compare_field("largest",         got.largest,         want.fields.largest);
      compare_field("worst_deviation", got.worst_deviation, want.fields.worst_deviation);
      compare_field("mean_value",      got.mean_value,      want.fields.mean_value);
      compare_field("batch_grade",     got.batch_grade,     want.fields.batch_grade);
      compare_field("summary_valid",   rsp_tlast,           want.closes);
   endtask

   // values read here are the ones the block sampled at this edge
   always @(posedge clock) begin
      if (reset) begin
         nominal = '0;
         band    = '0;
         clear_batch();
         expected_reports.delete();
         pending <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_NOMINAL: nominal = csr_wdata;
               CSR_BAND:    band    = csr_wdata[BAND_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            inspect_measurement(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready)
            check_report();
         pending <= expected_reports.size();
      end
   end

endmodule

FILE: tb/tolerance_batch_inspector_top_tb.sv
// ---------------------------------------------------------------------------
// tolerance_batch_inspector_top_tb
// drives measurement batches into the inspector under several nominal and
// band settings and idling patterns; the checker beside the block predicts
// every report and counts mismatches, this module gives the verdict
// ---------------------------------------------------------------------------
module tolerance_batch_inspector_top_tb;
   import tbi_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [SAMPLE_BITS-1:0] req_tdata  = '0;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index  = CSR_NOMINAL;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   int mismatches;
   int pending;
   int idle_pct  = 0;
   int stall_pct = 0;
   int items_sent;
   int batches_sent;
   int settings_written;

   tolerance_batch_inspector_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   inspection_checker outcome_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .pending    (pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic send_item(input logic [SAMPLE_BITS-1:0] meas, input logic last);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= meas;
      req_tlast  <= last;
      do
         @(posedge clock);
      while (!req_tready);
      items_sent++;
      if (last)
         batches_sent++;
   endtask

   task automatic set_limits(input logic [CSR_DATA_W-1:0] nom_word,
                             input logic [CSR_DATA_W-1:0] band_word);
      csr_we    <= 1'b1;
      csr_index <= CSR_NOMINAL;
      csr_wdata <= nom_word;
      @(posedge clock);
      csr_index <= CSR_BAND;
      csr_wdata <= band_word;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      settings_written++;
   endtask

   // stop sending, let every report come back, then allow the divider to settle
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (48) @(posedge clock);
   endtask

   // mostly near the band edges, with extremes and plain noise mixed in
   function automatic logic [SAMPLE_BITS-1:0] pick_measurement(input longint nom,
                                                              input longint band);
      longint                 v;
      longint                 span;
      logic [SAMPLE_BITS-1:0] r;

      span = band + band / 4 + 2;
      r    = SAMPLE_BITS'($urandom);
      case ($urandom_range(9))
         0: v = longint'($signed(r));
         1: begin
            case ($urandom_range(5))
               0:       v = -8388608;
               1:       v = 8388607;
               2:       v = nom - band;
               3:       v = nom + band;
               4:       v = nom - band - 1;
               default: v = nom + band + 1;
            endcase
         end
         default: v = nom - span + longint'($urandom_range(int'(2 * span)));
      endcase
      if (v > 8388607)
         v = 8388607;
      if (v < -8388608)
         v = -8388608;
      return v[SAMPLE_BITS-1:0];
   endfunction

   initial begin
      int                     idle_by_phase[4];
      int                     stall_by_phase[4];
      int                     batch_left;
      longint                 nom;
      longint                 band;
      logic [SAMPLE_BITS-1:0] r;
      logic [CSR_DATA_W-1:0]  band_word;

      idle_by_phase  = '{0, 48, 0, 27};
      stall_by_phase = '{0, 0, 48, 27};

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // band edges, grades at 60, 80 and 100 percent, a one-item batch
      set_limits(24'sd1000, 24'd50);
      send_item(24'sd1050, 1'b0);
      send_item(24'sd950, 1'b0);
      send_item(24'sd1000, 1'b0);
      send_item(24'sd1051, 1'b0);
      send_item(24'sd949, 1'b1);
      send_item(24'sd1000, 1'b0);
      send_item(24'sd1010, 1'b0);
      send_item(24'sd990, 1'b0);
      send_item(24'sd1049, 1'b0);
      send_item(24'sd2000, 1'b1);
      // negative mean truncates toward zero
      send_item(-24'sd3, 1'b0);
      send_item(-24'sd4, 1'b1);
      send_item(24'sd1000, 1'b1);
      wait_drained();
      // widest deviations with extreme nominal and band
      set_limits(-24'sd8388608, 24'h7FFFFF);
      send_item(24'sd8388607, 1'b0);
      send_item(-24'sd8388608, 1'b0);
      send_item(24'sd0, 1'b1);
      wait_drained();
      set_limits(24'sd8388607, 24'h800000);
      send_item(-24'sd8388608, 1'b0);
      send_item(24'sd8388607, 1'b1);
      wait_drained();

      for (int ph = 0; ph < 4; ph++) begin
         idle_pct  = idle_by_phase[ph];
         stall_pct = stall_by_phase[ph];
         for (int s = 0; s < 3; s++) begin
            r = SAMPLE_BITS'($urandom);
            case ($urandom_range(4))
               0:       nom = -8388608;
               1:       nom = 8388607;
               2:       nom = 0;
               default: nom = longint'($signed(r));
            endcase
            r = SAMPLE_BITS'($urandom);
            case ($urandom_range(4))
               0:       band_word = {r[23], 23'd0};
               1:       band_word = {r[23], 23'($urandom_range(1000))};
               2:       band_word = {r[23], 23'h7FFFFF};
               default: band_word = r;
            endcase
            band = longint'(band_word[BAND_W-1:0]);
            set_limits(nom[CSR_DATA_W-1:0], band_word);
            batch_left = 0;
            for (int i = 0; i < 92; i++) begin
               if (batch_left == 0)
                  batch_left = ($urandom_range(4) == 0) ? 1 : $urandom_range(24, 2);
               send_item(pick_measurement(nom, band), (batch_left == 1) || (i == 91));
               batch_left--;
            end
            wait_drained();
         end
      end

      $display("sent %0d measurements, %0d batches closed by tlast, %0d limit settings",
               items_sent, batches_sent, settings_written);
      $display("idling on each side and both, band edges, extreme limits and grades");
      if (mismatches == 0 && pending == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

FILE: tolerance_batch_inspector_top.f
+incdir+rtl
rtl/tbi_pkg.sv
rtl/tbi_stats.sv
rtl/tbi_divider.sv
rtl/tolerance_batch_inspector_top.sv
tb/inspection_checker.sv
tb/tolerance_batch_inspector_top_tb.sv
